[rtl/bum_pkg.sv]
// Shared types, constants and a helper function for the battery undervoltage monitor.
package bum_pkg;

    localparam int ADC_W          = 16;
    localparam int TIME_W         = 32;
    localparam int FILT_W         = 24;
    localparam int COUNT_W        = 16;
    localparam int SHIFT_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int HIST_DEPTH     = 3;
    localparam int HIST_PTR_W     = 2;
    localparam int TIME_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        MS_WAITING = 2'd0,
        MS_NORMAL  = 2'd1,
        MS_LOW     = 2'd2,
        MS_STALE   = 2'd3
    } t_mon_state;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_PROCESS = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR     = 3'd0,
        CFG_REC_THR     = 3'd1,
        CFG_LOW_CONFIRM = 3'd2,
        CFG_REC_CONFIRM = 3'd3,
        CFG_STALE_TMO   = 3'd4,
        CFG_FILT_SHIFT  = 3'd5
    } t_cfg_idx;

    localparam logic [ADC_W-1:0]   RST_LOW_THR     = 16'd31207;
    localparam logic [ADC_W-1:0]   RST_REC_THR     = 16'd32059;
    localparam logic [15:0]        RST_LOW_CONFIRM = 16'd500;
    localparam logic [15:0]        RST_REC_CONFIRM = 16'd2000;
    localparam logic [15:0]        RST_STALE_TMO   = 16'd1500;
    localparam logic [SHIFT_W-1:0] RST_FILT_SHIFT  = 4'd2;

    // Median of the filled history: zero when empty, the single value, the floored
    // mean of two, or the true median of three.
    function automatic logic [ADC_W-1:0] hist_median(
        input logic [ADC_W-1:0]      a_in,
        input logic [ADC_W-1:0]      b_in,
        input logic [ADC_W-1:0]      c_in,
        input logic [HIST_PTR_W-1:0] fill
    );
        logic [ADC_W-1:0] lo;
        logic [ADC_W-1:0] hi;
        logic [ADC_W-1:0] mid;
        logic [ADC_W:0]   sum;
        lo  = (a_in > b_in) ? b_in : a_in;
        hi  = (a_in > b_in) ? a_in : b_in;
        mid = (hi > c_in) ? c_in : hi;
        mid = (lo > mid) ? lo : mid;
        sum = {1'b0, a_in} + {1'b0, b_in};
        case (fill)
            2'd0:    hist_median = '0;
            2'd1:    hist_median = a_in;
            2'd2:    hist_median = sum[ADC_W:1];
            default: hist_median = mid;
        endcase
    endfunction

endpackage

[rtl/battery_undervoltage_monitor.sv]
// Top level of the battery undervoltage monitor: median filter, EMA, hysteresis and staleness.
//
//  Channel   Signals                                           Direction
//  -------   -----------------------------------------------   ---------
//  input     i_in_valid, o_in_stall, i_op, i_raw_adc, i_time_ms  in
//  output    o_out_valid, i_out_stall, o_monitor_state ...      out
//  config    i_cfg_we, i_cfg_index, i_cfg_data                  in
//
// Each transaction passes through the input register and then the evaluation stage,
// which writes the result register; one transaction can be taken every cycle while
// the result is not stalled. The evaluation stage depth is set by the median, the
// EMA step and the threshold compare in series.
// Reset is synchronous, sets config defaults, and clears monitor state and valid flags.
// A stalled result holds the evaluation stage, and that in turn stalls the input.
module battery_undervoltage_monitor #(
    parameter int TIME_BITS     = bum_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = bum_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [bum_pkg::ADC_W-1:0]        i_raw_adc,
    input  logic [bum_pkg::TIME_W-1:0]       i_time_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_monitor_state,
    output logic                             o_low_flag,
    output logic                             o_stale_flag,
    output logic [bum_pkg::FILT_W-1:0]       o_filtered_counts,
    output logic [bum_pkg::ADC_W-1:0]        o_median_counts,
    output logic [bum_pkg::ADC_W-1:0]        o_latest_raw,
    output logic [bum_pkg::TIME_W-1:0]       o_data_age_ms,
    output logic [bum_pkg::COUNT_W-1:0]      o_low_entries,
    output logic [bum_pkg::COUNT_W-1:0]      o_stale_entries,
    input  logic                             i_cfg_we,
    input  logic [bum_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bum_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bum_pkg::*;

    localparam int EMA_W = ADC_W + FRACTION_BITS;

    // Configuration registers.
    logic [ADC_W-1:0]   r_low_thr;
    logic [ADC_W-1:0]   r_rec_thr;
    logic [15:0]        r_low_confirm;
    logic [15:0]        r_rec_confirm;
    logic [15:0]        r_stale_tmo;
    logic [SHIFT_W-1:0] r_filt_shift;

    // Input register.
    logic                 r_in_valid;
    logic                 r_in_op;
    logic [ADC_W-1:0]     r_in_raw;
    logic [TIME_BITS-1:0] r_in_time;

    // Monitor state.
    logic [ADC_W-1:0]      r_hist [HIST_DEPTH];
    logic [HIST_PTR_W-1:0] r_fill;
    logic [HIST_PTR_W-1:0] r_ptr;
    logic [ADC_W-1:0]      r_pend_raw;
    logic [TIME_BITS-1:0]  r_pend_time;
    logic                  r_pend_new;
    logic                  r_seen;
    logic [EMA_W-1:0]      r_ema;
    logic                  r_seeded;
    logic                  r_low_latched;
    logic                  r_low_pending;
    logic [TIME_BITS-1:0]  r_low_since;
    logic                  r_rec_pending;
    logic [TIME_BITS-1:0]  r_rec_since;
    logic                  r_stale_latched;
    logic [COUNT_W-1:0]    r_low_count;
    logic [COUNT_W-1:0]    r_stale_count;
    logic [ADC_W-1:0]      r_last_raw;

    logic [ADC_W-1:0]      n_hist [HIST_DEPTH];
    logic [HIST_PTR_W-1:0] n_fill;
    logic [HIST_PTR_W-1:0] n_ptr;
    logic [ADC_W-1:0]      n_pend_raw;
    logic [TIME_BITS-1:0]  n_pend_time;
    logic                  n_pend_new;
    logic                  n_seen;
    logic [EMA_W-1:0]      n_ema;
    logic                  n_seeded;
    logic                  n_low_latched;
    logic                  n_low_pending;
    logic [TIME_BITS-1:0]  n_low_since;
    logic                  n_rec_pending;
    logic [TIME_BITS-1:0]  n_rec_since;
    logic                  n_stale_latched;
    logic [COUNT_W-1:0]    n_low_count;
    logic [COUNT_W-1:0]    n_stale_count;
    logic [ADC_W-1:0]      n_last_raw;
    logic [ADC_W-1:0]      n_median;
    logic [TIME_BITS-1:0]  n_age;
    t_mon_state            n_mon_state;

    // Result register.
    logic                 r_out_valid;
    t_mon_state           r_mon_state;
    logic                 r_out_low;
    logic                 r_out_stale;
    logic [FILT_W-1:0]    r_out_filt;
    logic [ADC_W-1:0]     r_out_median;
    logic [ADC_W-1:0]     r_out_latest;
    logic [TIME_W-1:0]    r_out_age;
    logic [COUNT_W-1:0]   r_out_low_cnt;
    logic [COUNT_W-1:0]   r_out_stale_cnt;

    logic stage_go;
    logic out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign stage_go   = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr     <= RST_LOW_THR;
            r_rec_thr     <= RST_REC_THR;
            r_low_confirm <= RST_LOW_CONFIRM;
            r_rec_confirm <= RST_REC_CONFIRM;
            r_stale_tmo   <= RST_STALE_TMO;
            r_filt_shift  <= RST_FILT_SHIFT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOW_THR:     r_low_thr     <= i_cfg_data;
                CFG_REC_THR:     r_rec_thr     <= i_cfg_data;
                CFG_LOW_CONFIRM: r_low_confirm <= i_cfg_data;
                CFG_REC_CONFIRM: r_rec_confirm <= i_cfg_data;
                CFG_STALE_TMO:   r_stale_tmo   <= i_cfg_data;
                CFG_FILT_SHIFT:  r_filt_shift  <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_op   <= i_op;
            r_in_raw  <= i_raw_adc;
            r_in_time <= i_time_ms[TIME_BITS-1:0];
        end
    end

    always_comb begin
        logic [EMA_W-1:0] target;
        logic [EMA_W:0]   round_add;
        logic [EMA_W:0]   down_step;
        logic [EMA_W-1:0] low_lvl;
        logic [EMA_W-1:0] rec_lvl;
        logic [TIME_BITS-1:0] age_seen;

        n_hist          = r_hist;
        n_fill          = r_fill;
        n_ptr           = r_ptr;
        n_pend_raw      = r_pend_raw;
        n_pend_time     = r_pend_time;
        n_pend_new      = r_pend_new;
        n_seen          = r_seen;
        n_ema           = r_ema;
        n_seeded        = r_seeded;
        n_low_latched   = r_low_latched;
        n_low_pending   = r_low_pending;
        n_low_since     = r_low_since;
        n_rec_pending   = r_rec_pending;
        n_rec_since     = r_rec_since;
        n_stale_latched = r_stale_latched;
        n_low_count     = r_low_count;
        n_stale_count   = r_stale_count;
        n_last_raw      = r_last_raw;
        n_median        = hist_median(r_hist[0], r_hist[1], r_hist[2], r_fill);
        target          = '0;
        round_add       = '0;
        down_step       = '0;
        low_lvl         = EMA_W'(r_low_thr) << FRACTION_BITS;
        rec_lvl         = EMA_W'(r_rec_thr) << FRACTION_BITS;

        if (r_in_op == OP_SAMPLE) begin
            n_pend_raw  = r_in_raw;
            n_pend_time = r_in_time;
            n_pend_new  = 1'b1;
            n_seen      = 1'b1;
        end else if (r_pend_new) begin
            n_pend_new       = 1'b0;
            n_hist[r_ptr]    = r_pend_raw;
            n_ptr            = (r_ptr == HIST_PTR_W'(HIST_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            n_fill           = (r_fill == HIST_PTR_W'(HIST_DEPTH)) ? r_fill : r_fill + 1'b1;
            n_last_raw       = r_pend_raw;
            n_median         = hist_median(n_hist[0], n_hist[1], n_hist[2], n_fill);
            target           = EMA_W'(n_median) << FRACTION_BITS;
            n_seeded         = 1'b1;
            if (!r_seeded) begin
                n_ema = target;
            end else if (target >= r_ema) begin
                n_ema = r_ema + ((target - r_ema) >> r_filt_shift);
            end else begin
                round_add = ((EMA_W + 1)'(1) << r_filt_shift) - 1'b1;
                down_step = ({1'b0, r_ema - target} + round_add) >> r_filt_shift;
                n_ema     = r_ema - down_step[EMA_W-1:0];
            end
            n_stale_latched = 1'b0;

            if (!r_low_latched) begin
                n_rec_pending = 1'b0;
                if (n_ema < low_lvl) begin
                    if (!r_low_pending) begin
                        n_low_pending = 1'b1;
                        n_low_since   = r_in_time;
                    end else if ((r_in_time - r_low_since) >= TIME_BITS'(r_low_confirm)) begin
                        n_low_latched = 1'b1;
                        n_low_count   = r_low_count + 1'b1;
                        n_low_pending = 1'b0;
                    end
                end else begin
                    n_low_pending = 1'b0;
                end
            end else begin
                n_low_pending = 1'b0;
                if (n_ema > rec_lvl) begin
                    if (!r_rec_pending) begin
                        n_rec_pending = 1'b1;
                        n_rec_since   = r_in_time;
                    end else if ((r_in_time - r_rec_since) >= TIME_BITS'(r_rec_confirm)) begin
                        n_low_latched = 1'b0;
                        n_rec_pending = 1'b0;
                    end
                end else begin
                    n_rec_pending = 1'b0;
                end
            end
        end

        age_seen = r_in_time - n_pend_time;
        if (r_in_op == OP_PROCESS && n_seen && age_seen > TIME_BITS'(r_stale_tmo)) begin
            if (!n_stale_latched) begin
                n_stale_count = r_stale_count + 1'b1;
            end
            n_stale_latched = 1'b1;
        end

        if (!n_seen) begin
            n_age       = r_in_time;
            n_mon_state = MS_WAITING;
        end else begin
            n_age       = age_seen;
            n_mon_state = n_stale_latched ? MS_STALE : (n_low_latched ? MS_LOW : MS_NORMAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_fill          <= '0;
            r_ptr           <= '0;
            r_pend_raw      <= '0;
            r_pend_time     <= '0;
            r_pend_new      <= 1'b0;
            r_seen          <= 1'b0;
            r_ema           <= '0;
            r_seeded        <= 1'b0;
            r_low_latched   <= 1'b0;
            r_low_pending   <= 1'b0;
            r_low_since     <= '0;
            r_rec_pending   <= 1'b0;
            r_rec_since     <= '0;
            r_stale_latched <= 1'b0;
            r_low_count     <= '0;
            r_stale_count   <= '0;
            r_last_raw      <= '0;
        end else if (stage_go) begin
            r_hist          <= n_hist;
            r_fill          <= n_fill;
            r_ptr           <= n_ptr;
            r_pend_raw      <= n_pend_raw;
            r_pend_time     <= n_pend_time;
            r_pend_new      <= n_pend_new;
            r_seen          <= n_seen;
            r_ema           <= n_ema;
            r_seeded        <= n_seeded;
            r_low_latched   <= n_low_latched;
            r_low_pending   <= n_low_pending;
            r_low_since     <= n_low_since;
            r_rec_pending   <= n_rec_pending;
            r_rec_since     <= n_rec_since;
            r_stale_latched <= n_stale_latched;
            r_low_count     <= n_low_count;
            r_stale_count   <= n_stale_count;
            r_last_raw      <= n_last_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go) begin
            r_mon_state     <= n_mon_state;
            r_out_low       <= n_low_latched;
            r_out_stale     <= n_stale_latched;
            r_out_filt      <= FILT_W'(n_ema);
            r_out_median    <= n_median;
            r_out_latest    <= n_last_raw;
            r_out_age       <= TIME_W'(n_age);
            r_out_low_cnt   <= n_low_count;
            r_out_stale_cnt <= n_stale_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_monitor_state   = r_mon_state;
    assign o_low_flag        = r_out_low;
    assign o_stale_flag      = r_out_stale;
    assign o_filtered_counts = r_out_filt;
    assign o_median_counts   = r_out_median;
    assign o_latest_raw      = r_out_latest;
    assign o_data_age_ms     = r_out_age;
    assign o_low_entries     = r_out_low_cnt;
    assign o_stale_entries   = r_out_stale_cnt;

endmodule

[rtl/bum_checker.sv]
// Port-level checker for the battery undervoltage monitor and its bind statement.
module bum_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [1:0]                     o_monitor_state,
    input logic                           o_low_flag,
    input logic                           o_stale_flag,
    input logic [bum_pkg::COUNT_W-1:0]    o_low_entries,
    input logic [bum_pkg::COUNT_W-1:0]    o_stale_entries
);
    import bum_pkg::*;

    // No result may be offered in the cycle after reset.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The reported state must agree with the latched flags.
    a_state_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_monitor_state == MS_STALE) == o_stale_flag) &&
            (o_monitor_state != MS_LOW || o_low_flag) &&
            (o_monitor_state != MS_NORMAL || !o_low_flag))
        else $error("monitor state disagrees with flags");

    // Before any sample the monitor cannot flag anything.
    a_waiting_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_monitor_state == MS_WAITING |->
            !o_low_flag && !o_stale_flag && o_low_entries == '0 && o_stale_entries == '0)
        else $error("flags or counts set while waiting for a sample");

    // A stalled transaction holds its result.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_monitor_state) && $stable(o_low_entries) &&
            $stable(o_stale_entries))
        else $error("stalled result changed");

endmodule

bind battery_undervoltage_monitor bum_checker u_bum_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_monitor_state (o_monitor_state),
    .o_low_flag      (o_low_flag),
    .o_stale_flag    (o_stale_flag),
    .o_low_entries   (o_low_entries),
    .o_stale_entries (o_stale_entries)
);
